// ===== rtl/obpd_pkg.sv =====
// Shared types and constants of the oriented box to point distance block.
`timescale 1ns / 1ps
`default_nettype none
package obpd_pkg;

   localparam int unsigned EXTENT_WIDTH = 16;
   localparam int unsigned TRIG_WIDTH   = 16;
   localparam int unsigned DIST_WIDTH   = 18;
   localparam int unsigned CSR_ADDR_WIDTH = 2;
   localparam int unsigned RSP_DATA_WIDTH = 24;

   // Distances saturate at 1000 m; the vehicle-frame work runs in 1/512 m.
   localparam logic [DIST_WIDTH-1:0] MAX_DIST = 18'd256000;
   localparam logic [20:0] DIST_CLAMP   = 21'd512000;
   localparam logic [20:0] EXCESS_CLAMP = 21'd1048576;

   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      REG_FWD_EXTENT   = 2'd0,
      REG_REAR_EXTENT  = 2'd1,
      REG_LEFT_EXTENT  = 2'd2,
      REG_RIGHT_EXTENT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [EXTENT_WIDTH-1:0] fwd_extent;
      logic [EXTENT_WIDTH-1:0] rear_extent;
      logic [EXTENT_WIDTH-1:0] left_extent;
      logic [EXTENT_WIDTH-1:0] right_extent;
   } hitbox_type;

   // Classification made when a word is accepted.
   typedef struct packed {
      logic measure;
      logic last;
   } item_flags_type;

   typedef struct packed {
      logic valid;
      item_flags_type flags;
   } queue_head_type;

endpackage
`default_nettype wire

// ===== rtl/obpd_front.sv =====
// Input side: accepts words, classifies them and queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none
module obpd_front #(
   parameter int unsigned DATA_BITS = 128
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire logic [DATA_BITS-1:0] in_data,
   input  wire logic                 in_point_valid,
   input  wire logic                 in_last,
   output obpd_pkg::queue_head_type  head,
   output logic [DATA_BITS-1:0]      head_data,
   input  wire logic                 pop
);

   localparam int unsigned DEPTH = 4;
   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned ENTRY_W = DATA_BITS + 2;

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0] count_ff, count_in;
   logic push, do_pop;
   obpd_pkg::item_flags_type flags_in;
   logic [ENTRY_W-1:0] head_entry;

   assign in_ready = (count_ff != PTR_W'(0) + (PTR_W+1)'(DEPTH));
   assign push     = in_valid && in_ready;
   assign do_pop   = pop && (count_ff != '0);

   // A word without a point still has to reach the back end when it ends a query.
   assign flags_in.measure = in_point_valid;
   assign flags_in.last    = in_last;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= {flags_in, in_data};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head_entry = mem[rd_ptr_ff];
   assign head.valid = (count_ff != '0);
   assign head.flags = head_entry[ENTRY_W-1 -: 2];
   assign head_data  = head_entry[DATA_BITS-1:0];

endmodule
`default_nettype wire

// ===== rtl/obpd_back.sv =====
// Back end: frame turn, box test, corner square root and running minimum per query.
`timescale 1ns / 1ps
`default_nettype none
module obpd_back #(
   parameter int unsigned COORD_WIDTH    = 24,
   parameter int unsigned TRIG_FRAC_BITS = 14
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  obpd_pkg::hitbox_type               hitbox,
   input  obpd_pkg::queue_head_type           head,
   input  wire logic [4*COORD_WIDTH+31:0]     head_data,
   output logic                               pop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_collision,
   output logic [obpd_pkg::DIST_WIDTH-1:0]    rsp_min
);

   localparam int unsigned W  = COORD_WIDTH;
   localparam int unsigned T  = TRIG_FRAC_BITS;
   localparam int unsigned DW = (W + 3 > 27) ? W + 3 : 27;
   localparam int unsigned BW = 22;
   localparam int unsigned MW = DW + BW;
   localparam logic signed [MW:0] HALF = (MW+1)'(64'd1 << (T - 1));
   localparam int unsigned RAD_W = 42;

   typedef enum logic [3:0] {
      S_IDLE, S_ROT, S_OFF, S_TURN, S_ABS, S_CLASS, S_SQ, S_RINIT, S_ROOT, S_UPD
   } state_type;

   state_type state_ff, state_in;
   logic signed [MW-1:0] m_ff [4];
   logic signed [MW-1:0] m_in [4];
   logic signed [DW-1:0] mul_a [4];
   logic signed [BW-1:0] mul_b [4];
   logic signed [DW-1:0] difx_ff, difx_in, dify_ff, dify_in, dx_ff, dx_in, dy_ff, dy_in;
   logic signed [15:0] c_ff, c_in, s_ff, s_in;
   logic [MW:0] ax_ff, ax_in, ay_ff, ay_in;
   logic [20:0] ex_ff, ex_in, ey_ff, ey_in, d_ff, d_in;
   logic [RAD_W-1:0] num_ff, num_in, root_ff, root_in;
   logic [4:0] cnt_ff, cnt_in;
   logic dok_ff, dok_in, last_ff, last_in, hit_ff, hit_in;
   logic [obpd_pkg::DIST_WIDTH-1:0] min_ff, min_in, rmin_ff, rmin_in;
   logic rvalid_ff, rvalid_in, rcol_ff, rcol_in;

   logic signed [W-1:0] ox, oy, px, py;
   logic signed [16:0] cx, cy;
   logic [16:0] hl, hw;
   logic signed [MW:0] rx, ry, tx, ty, vx, vy;
   logic [MW:0] exr, eyr;
   logic [20:0] exc, eyc, dcl;
   logic [RAD_W-1:0] rbit, trial;
   logic [19:0] half_d;

   assign ox = head_data[W-1:0];
   assign oy = head_data[2*W-1:W];
   assign px = head_data[3*W-1:2*W];
   assign py = head_data[4*W-1:3*W];
   assign cx = $signed({1'b0, hitbox.fwd_extent}) - $signed({1'b0, hitbox.rear_extent});
   assign cy = $signed({1'b0, hitbox.left_extent}) - $signed({1'b0, hitbox.right_extent});
   assign hl = {1'b0, hitbox.fwd_extent} + {1'b0, hitbox.rear_extent};
   assign hw = {1'b0, hitbox.left_extent} + {1'b0, hitbox.right_extent};

   // Four shared multipliers, operands chosen by the sequencer step.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         mul_a[i] = '0;
         mul_b[i] = '0;
      end
      unique case (state_ff)
         S_ROT: begin
            mul_a[0] = DW'(cx); mul_b[0] = BW'(c_ff);
            mul_a[1] = DW'(cy); mul_b[1] = BW'(s_ff);
            mul_a[2] = DW'(cx); mul_b[2] = BW'(s_ff);
            mul_a[3] = DW'(cy); mul_b[3] = BW'(c_ff);
         end
         S_TURN: begin
            mul_a[0] = dx_ff; mul_b[0] = BW'(c_ff);
            mul_a[1] = dy_ff; mul_b[1] = BW'(s_ff);
            mul_a[2] = dy_ff; mul_b[2] = BW'(c_ff);
            mul_a[3] = dx_ff; mul_b[3] = BW'(s_ff);
         end
         S_SQ: begin
            mul_a[0] = DW'(ex_ff); mul_b[0] = BW'(ex_ff);
            mul_a[1] = DW'(ey_ff); mul_b[1] = BW'(ey_ff);
         end
         default: begin
         end
      endcase
      for (int i = 0; i < 4; i++) begin
         m_in[i] = mul_a[i] * mul_b[i];
      end
   end

   always_comb begin
      rx = $signed({m_ff[0][MW-1], m_ff[0]}) - $signed({m_ff[1][MW-1], m_ff[1]});
      ry = $signed({m_ff[2][MW-1], m_ff[2]}) + $signed({m_ff[3][MW-1], m_ff[3]});
      tx = $signed({m_ff[0][MW-1], m_ff[0]}) + $signed({m_ff[1][MW-1], m_ff[1]});
      ty = $signed({m_ff[2][MW-1], m_ff[2]}) - $signed({m_ff[3][MW-1], m_ff[3]});
      // Rounding half up is a floor after adding one half.
      vx = (tx + HALF) >>> T;
      vy = (ty + HALF) >>> T;
      exr = ax_ff - (MW+1)'(hl);
      eyr = ay_ff - (MW+1)'(hw);
      exc = (exr > (MW+1)'(obpd_pkg::EXCESS_CLAMP)) ? obpd_pkg::EXCESS_CLAMP : exr[20:0];
      eyc = (eyr > (MW+1)'(obpd_pkg::EXCESS_CLAMP)) ? obpd_pkg::EXCESS_CLAMP : eyr[20:0];
      rbit  = RAD_W'(1) << {cnt_ff, 1'b0};
      trial = root_ff + rbit;
      dcl = (d_ff > obpd_pkg::DIST_CLAMP) ? obpd_pkg::DIST_CLAMP : d_ff;
      half_d = (dcl[19:0] + 20'd1) >> 1;
   end

   always_comb begin
      state_in = state_ff;
      difx_in = difx_ff; dify_in = dify_ff;
      c_in = c_ff; s_in = s_ff;
      dx_in = dx_ff; dy_in = dy_ff;
      ax_in = ax_ff; ay_in = ay_ff;
      ex_in = ex_ff; ey_in = ey_ff;
      d_in = d_ff;
      num_in = num_ff; root_in = root_ff; cnt_in = cnt_ff;
      dok_in = dok_ff; last_in = last_ff;
      hit_in = hit_ff; min_in = min_ff;
      rvalid_in = rvalid_ff && !rsp_ready;
      rcol_in = rcol_ff; rmin_in = rmin_ff;
      pop = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (head.valid && !rvalid_ff) begin
               pop = 1'b1;
               last_in = head.flags.last;
               difx_in = (DW'(ox) - DW'(px)) <<< 1;
               dify_in = (DW'(oy) - DW'(py)) <<< 1;
               c_in = head_data[4*W+15:4*W];
               s_in = head_data[4*W+31:4*W+16];
               dok_in = 1'b0;
               state_in = (head.flags.measure && !hit_ff) ? S_ROT : S_UPD;
            end
         end
         S_ROT: state_in = S_OFF;
         S_OFF: begin
            dx_in = DW'(difx_ff - ((rx + HALF) >>> T));
            dy_in = DW'(dify_ff - ((ry + HALF) >>> T));
            state_in = S_TURN;
         end
         S_TURN: state_in = S_ABS;
         S_ABS: begin
            ax_in = vx[MW] ? (MW+1)'(-vx) : (MW+1)'(vx);
            ay_in = vy[MW] ? (MW+1)'(-vy) : (MW+1)'(vy);
            state_in = S_CLASS;
         end
         S_CLASS: begin
            ex_in = exc;
            ey_in = eyc;
            priority if (ax_ff <= (MW+1)'(hl) && ay_ff <= (MW+1)'(hw)) begin
               hit_in = 1'b1;
               min_in = '0;
               state_in = S_UPD;
            end else if (ax_ff > (MW+1)'(hl) && ay_ff > (MW+1)'(hw)) begin
               state_in = S_SQ;
            end else if (ax_ff > (MW+1)'(hl)) begin
               d_in = exc;
               dok_in = 1'b1;
               state_in = S_UPD;
            end else begin
               d_in = eyc;
               dok_in = 1'b1;
               state_in = S_UPD;
            end
         end
         S_SQ: state_in = S_RINIT;
         S_RINIT: begin
            num_in = RAD_W'(m_ff[0]) + RAD_W'(m_ff[1]);
            root_in = '0;
            cnt_in = 5'd20;
            state_in = S_ROOT;
         end
         S_ROOT: begin
            // One root bit per cycle, restoring form.
            if (num_ff >= trial) begin
               num_in = num_ff - trial;
               root_in = (root_ff >> 1) + rbit;
            end else begin
               root_in = root_ff >> 1;
            end
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               d_in = root_in[20:0];
               dok_in = 1'b1;
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            if (dok_ff && (half_d[17:0] < min_ff)) begin
               min_in = half_d[17:0];
            end
            if (last_ff) begin
               rvalid_in = 1'b1;
               rcol_in = hit_ff;
               rmin_in = (dok_ff && (half_d[17:0] < min_ff)) ? half_d[17:0] : min_ff;
               hit_in = 1'b0;
               min_in = obpd_pkg::MAX_DIST;
            end
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         m_ff[i] <= m_in[i];
      end
      difx_ff <= difx_in; dify_ff <= dify_in;
      c_ff <= c_in; s_ff <= s_in;
      dx_ff <= dx_in; dy_ff <= dy_in;
      ax_ff <= ax_in; ay_ff <= ay_in;
      ex_ff <= ex_in; ey_ff <= ey_in;
      d_ff <= d_in;
      num_ff <= num_in; root_ff <= root_in; cnt_ff <= cnt_in;
      dok_ff <= dok_in; last_ff <= last_in;
      rcol_ff <= rcol_in; rmin_ff <= rmin_in;
      if (reset) begin
         state_ff  <= S_IDLE;
         hit_ff    <= 1'b0;
         min_ff    <= obpd_pkg::MAX_DIST;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         hit_ff    <= hit_in;
         min_ff    <= min_in;
         rvalid_ff <= rvalid_in;
      end
   end

   assign rsp_valid     = rvalid_ff;
   assign rsp_collision = rcol_ff;
   assign rsp_min       = rmin_ff;

endmodule
`default_nettype wire

// ===== rtl/oriented_box_point_distance.sv =====
// Top level: hitbox registers, input queue and distance back end.
//
//   channel  direction  handshake               payload
//   req      in         req_tvalid/req_tready   tdata points and pose, tuser, tlast
//   rsp      out        rsp_tvalid/rsp_tready   tdata distance, tuser collision
//   csr      in         csr_we                  csr_addr, csr_wdata
//
// A point word goes through the frame turn, the box test and the update when the
// end or side distance applies or the point is inside the box, and also through
// the corner square root (one root bit per cycle) when that runs. Words without
// a point, or after a hit, go from idle straight to the update. A four-word queue
// keeps accepting while the back end works or a result waits. Reset is synchronous
// and clears the queue, the query state and the hitbox to its defaults.
`timescale 1ns / 1ps
`default_nettype none
module oriented_box_point_distance #(
   parameter int unsigned COORD_WIDTH    = 24,
   parameter int unsigned TRIG_FRAC_BITS = 14
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // obstacle_x, obstacle_y, pose_x, pose_y, cos_heading, sin_heading, zero fill
   input  wire logic [((4*COORD_WIDTH+32+7)/8)*8-1:0] req_tdata,
   // point_valid
   input  wire logic req_tuser,
   input  wire logic req_tlast,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // minimum distance, zero fill
   output logic [obpd_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   // collision
   output logic      rsp_tuser,
   input  wire logic csr_we,
   input  wire logic [obpd_pkg::CSR_ADDR_WIDTH-1:0] csr_addr,
   input  wire logic [obpd_pkg::EXTENT_WIDTH-1:0]   csr_wdata
);

   localparam int unsigned DATA_BITS = 4 * COORD_WIDTH + 32;

   obpd_pkg::hitbox_type hitbox_ff, hitbox_in;
   obpd_pkg::queue_head_type head;
   logic [DATA_BITS-1:0] head_data;
   logic pop;
   logic [obpd_pkg::DIST_WIDTH-1:0] rsp_min;

   always_comb begin
      hitbox_in = hitbox_ff;
      if (csr_we) begin
         unique case (obpd_pkg::csr_index_type'(csr_addr))
            obpd_pkg::REG_FWD_EXTENT:   hitbox_in.fwd_extent   = csr_wdata;
            obpd_pkg::REG_REAR_EXTENT:  hitbox_in.rear_extent  = csr_wdata;
            obpd_pkg::REG_LEFT_EXTENT:  hitbox_in.left_extent  = csr_wdata;
            obpd_pkg::REG_RIGHT_EXTENT: hitbox_in.right_extent = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hitbox_ff.fwd_extent   <= 16'd256;
         hitbox_ff.rear_extent  <= 16'd256;
         hitbox_ff.left_extent  <= 16'd128;
         hitbox_ff.right_extent <= 16'd128;
      end else begin
         hitbox_ff <= hitbox_in;
      end
   end

   obpd_front #(.DATA_BITS(DATA_BITS)) u_front (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .in_data        (req_tdata[DATA_BITS-1:0]),
      .in_point_valid (req_tuser),
      .in_last        (req_tlast),
      .head           (head),
      .head_data      (head_data),
      .pop            (pop)
   );

   obpd_back #(
      .COORD_WIDTH    (COORD_WIDTH),
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .hitbox        (hitbox_ff),
      .head          (head),
      .head_data     (head_data),
      .pop           (pop),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_collision (rsp_tuser),
      .rsp_min       (rsp_min)
   );

   assign rsp_tdata = {{(obpd_pkg::RSP_DATA_WIDTH - obpd_pkg::DIST_WIDTH){1'b0}}, rsp_min};

endmodule
`default_nettype wire

// ===== rtl/obpd_checker.sv =====
// Port-level checks of the oriented box to point distance block, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
module obpd_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_tvalid,
   input wire logic rsp_tready,
   input wire logic [obpd_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   input wire logic rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   a_hit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[17:0] == 18'd0)
      else $error("collision reported with nonzero distance");

   a_dist_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[17:0] <= obpd_pkg::MAX_DIST)
      else $error("distance above the saturation limit");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind oriented_box_point_distance obpd_checker u_obpd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

// ===== dv/oriented_box_point_distance_tb.sv =====
// Self-checking testbench for the oriented box to point distance block.
`timescale 1ns / 1ps
`default_nettype none
module oriented_box_point_distance_tb;

   localparam int CW = 24;
   localparam int TF = 14;
   localparam int REQ_W = ((4*CW+32+7)/8)*8;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct {
      logic [CW-1:0] obs_x, obs_y, pose_x, pose_y;
      logic [15:0]   cos_h, sin_h;
      logic          has_point, last;
   } point_word_type;

   typedef struct {
      logic                            collision;
      logic [obpd_pkg::DIST_WIDTH-1:0] best_dist;
   } query_result_type;

   class query_scoreboard;
      obpd_pkg::hitbox_type            box;
      logic [obpd_pkg::DIST_WIDTH-1:0] run_min;
      bit                              hit;
      query_result_type                pending[$];
      int                              mismatches;
      int                              results_seen;
      int                              hits_seen;

      function new();
         box = '{16'd256, 16'd256, 16'd128, 16'd128};
         run_min = obpd_pkg::MAX_DIST;
         hit = 0;
      endfunction

      // Divide by 2^TF, ties go toward plus infinity.
      function longint round_trig(longint v);
         return (v + (longint'(1) << (TF-1))) >>> TF;
      endfunction

      function longint isqrt(longint n);
         longint r;
         r = 0;
         for (int b = 21; b >= 0; b--)
            if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= n)
               r = r + (longint'(1) << b);
         return r;
      endfunction

      // Distance in 1/256 m, or -1 when the point is inside the box.
      function longint box_distance(point_word_type w);
         longint ox, oy, px, py, c, s, cx, cy, hl, hw, dx, dy, ax, ay, ex, ey, d;
         ox = longint'($signed(w.obs_x));  oy = longint'($signed(w.obs_y));
         px = longint'($signed(w.pose_x)); py = longint'($signed(w.pose_y));
         c = longint'($signed(w.cos_h));   s = longint'($signed(w.sin_h));
         cx = longint'(box.fwd_extent) - longint'(box.rear_extent);
         cy = longint'(box.left_extent) - longint'(box.right_extent);
         hl = longint'(box.fwd_extent) + longint'(box.rear_extent);
         hw = longint'(box.left_extent) + longint'(box.right_extent);
         dx = 2*(ox-px) - round_trig(cx*c - cy*s);
         dy = 2*(oy-py) - round_trig(cx*s + cy*c);
         ax = round_trig(c*dx + s*dy);
         ay = round_trig(c*dy - s*dx);
         if (ax < 0) ax = -ax;
         if (ay < 0) ay = -ay;
         if (ax <= hl && ay <= hw) return -1;
         if (ax > hl && ay > hw) begin
            ex = ax - hl; ey = ay - hw;
            if (ex > obpd_pkg::EXCESS_CLAMP) ex = obpd_pkg::EXCESS_CLAMP;
            if (ey > obpd_pkg::EXCESS_CLAMP) ey = obpd_pkg::EXCESS_CLAMP;
            d = isqrt(ex*ex + ey*ey);
         end else if (ax > hl) d = ax - hl;
         else d = ay - hw;
         if (d > obpd_pkg::DIST_CLAMP) d = obpd_pkg::DIST_CLAMP;
         return (d + 1) >>> 1;
      endfunction

      function void note_word(point_word_type w);
         longint d;
         query_result_type r;
         if (w.has_point && !hit) begin
            d = box_distance(w);
            if (d < 0) begin
               hit = 1;
               run_min = '0;
            end else if (d < run_min) run_min = d[obpd_pkg::DIST_WIDTH-1:0];
         end
         if (w.last) begin
            r.collision = hit;
            r.best_dist = run_min;
            pending = {pending, r};
            run_min = obpd_pkg::MAX_DIST;
            hit = 0;
         end
      endfunction

      function void check_result(logic coll, logic [obpd_pkg::RSP_DATA_WIDTH-1:0] data);
         query_result_type e;
         results_seen++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result: coll=%0d dist=%0d", coll, data);
            return;
         end
         e = pending[0];
         pending.delete(0);
         if (coll) hits_seen++;
         if (coll !== e.collision ||
             data !== {{(obpd_pkg::RSP_DATA_WIDTH-obpd_pkg::DIST_WIDTH){1'b0}}, e.best_dist})
         begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected coll=%0d dist=%0d, got coll=%0d dist=%0d",
                        e.collision, e.best_dist, coll, data);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0, req_tuser = 0, req_tlast = 0;
   logic [REQ_W-1:0] req_tdata = '0;
   logic req_tready;
   logic rsp_tvalid, rsp_tuser;
   logic rsp_tready = 0;
   logic [obpd_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic csr_we = 0;
   logic [obpd_pkg::CSR_ADDR_WIDTH-1:0] csr_addr = '0;
   logic [obpd_pkg::EXTENT_WIDTH-1:0] csr_wdata = '0;

   oriented_box_point_distance DUT (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   query_scoreboard board = new();
   bit    idle_off = 0;
   bit    long_hold = 0;
   int    cycles = 0;
   int    words_sent = 0;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("** oriented_box_point_distance: FAILED **");
         $finish;
      end
   end

   // Result side: random back-pressure bursts, plus one long hold-off.
   initial begin : result_side
      int n;
      @(posedge clock iff !reset);
      forever begin
         if (long_hold) begin
            rsp_tready <= 0;
            repeat (300) @(posedge clock);
            long_hold = 0;
         end else if (!idle_off && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 0;
            n = $urandom_range(1, 10);
            repeat (n) @(posedge clock);
         end else begin
            rsp_tready <= 1;
            n = $urandom_range(1, 20);
            repeat (n) @(posedge clock);
         end
      end
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tuser, rsp_tdata);

   task automatic send_word(point_word_type w);
      if (!idle_off && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {{(REQ_W-4*CW-32){1'b0}}, w.sin_h, w.cos_h,
                    w.pose_y, w.pose_x, w.obs_y, w.obs_x};
      req_tuser <= w.has_point;
      req_tlast <= w.last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_word(w);
      words_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_csr(obpd_pkg::csr_index_type idx,
                            logic [obpd_pkg::EXTENT_WIDTH-1:0] v);
      csr_we <= 1;
      csr_addr <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      case (idx)
         obpd_pkg::REG_FWD_EXTENT:   board.box.fwd_extent = v;
         obpd_pkg::REG_REAR_EXTENT:  board.box.rear_extent = v;
         obpd_pkg::REG_LEFT_EXTENT:  board.box.left_extent = v;
         obpd_pkg::REG_RIGHT_EXTENT: board.box.right_extent = v;
      endcase
   endtask

   function automatic logic [15:0] random_trig();
      int a;
      a = $urandom_range(0, 7);
      case (a)
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return 16'd0;
         3: return 16'h8000;
         4: return 16'h7fff;
         default: return 16'($urandom_range(0, 32768)) - 16'd16384;
      endcase
   endfunction

   // Obstacles mostly near the pose so hits and all distance cases appear.
   function automatic point_word_type random_word(logic [CW-1:0] px, logic [CW-1:0] py,
                                                  logic [15:0] c, logic [15:0] s);
      point_word_type w;
      int spread;
      w.pose_x = px; w.pose_y = py; w.cos_h = c; w.sin_h = s;
      spread = ($urandom_range(0, 5) == 0) ? 0 : (1 << $urandom_range(6, 12));
      if (spread == 0) begin
         w.obs_x = CW'($urandom); w.obs_y = CW'($urandom);
      end else begin
         w.obs_x = px + CW'($signed($urandom_range(0, 2*spread)) - spread);
         w.obs_y = py + CW'($signed($urandom_range(0, 2*spread)) - spread);
      end
      w.has_point = ($urandom_range(0, 9) != 0);
      w.last = 0;
      return w;
   endfunction

   task automatic random_queries(int words);
      point_word_type w;
      logic [CW-1:0] px, py;
      logic [15:0] c, s;
      int len, sent;
      sent = 0;
      while (sent < words) begin
         px = ($urandom_range(0, 3) == 0) ? CW'($urandom) : CW'($urandom_range(0, 4095));
         py = ($urandom_range(0, 3) == 0) ? CW'($urandom) : CW'($urandom_range(0, 4095));
         c = random_trig(); s = random_trig();
         len = $urandom_range(1, 8);
         for (int k = 0; k < len; k++) begin
            w = random_word(px, py, c, s);
            w.last = (k == len - 1);
            send_word(w);
            sent++;
         end
      end
   endtask

   task automatic directed();
      point_word_type w;
      logic [CW-1:0] ext[4] = '{24'h7fffff, 24'h800000, 24'h000000, 24'hffffff};
      w = '{default: '0};
      w.cos_h = 16'sd16384;
      // Empty query, then a point at the origin (a hit) followed by an ignored point.
      w.last = 1; send_word(w);
      w.has_point = 1; w.last = 0; send_word(w);
      w.obs_x = 24'd5000; w.last = 1; send_word(w);
      // Extreme coordinates, and trig values in all combinations of sign.
      for (int i = 0; i < 4; i++) begin
         w.obs_x = ext[i]; w.obs_y = ext[3-i];
         w.pose_x = ext[(i+1)%4]; w.pose_y = ext[(i+2)%4];
         w.cos_h = (i % 2) ? 16'h8000 : 16'h7fff;
         w.sin_h = (i < 2) ? -16'sd16384 : 16'sd16384;
         w.last = (i == 3);
         send_word(w);
      end
      // End, side and corner distances and a point on the box edge against the default box.
      w = '{default: '0};
      w.cos_h = 16'sd16384; w.has_point = 1; w.last = 1;
      w.obs_x = 24'd600; send_word(w);
      w.obs_x = 0; w.obs_y = 24'd300; send_word(w);
      w.obs_x = -24'sd700; w.obs_y = -24'sd400; send_word(w);
      w.obs_x = 24'd256; w.obs_y = 24'd128; send_word(w);
      // Non-unit trig values and an empty word closing a query.
      w.cos_h = 16'd3; w.sin_h = 16'd9000; w.obs_x = 24'd900; w.last = 0; send_word(w);
      w.has_point = 0; w.last = 1; send_word(w);
   endtask

   initial begin : stimulus
      logic [obpd_pkg::EXTENT_WIDTH-1:0] box_sets[5][4];
      box_sets = '{'{16'd0, 16'd0, 16'd0, 16'd0},
                   '{16'hffff, 16'hffff, 16'hffff, 16'hffff},
                   '{16'hffff, 16'd0, 16'd0, 16'hffff},
                   '{16'd1000, 16'd40, 16'd300, 16'd700},
                   '{16'd256, 16'd256, 16'd128, 16'd128}};
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      directed();
      drain();
      for (int p = 0; p < 5; p++) begin
         write_csr(obpd_pkg::REG_FWD_EXTENT, box_sets[p][0]);
         write_csr(obpd_pkg::REG_REAR_EXTENT, box_sets[p][1]);
         write_csr(obpd_pkg::REG_LEFT_EXTENT, box_sets[p][2]);
         write_csr(obpd_pkg::REG_RIGHT_EXTENT, box_sets[p][3]);
         if (p == 1) long_hold = 1;
         if (p == 4) begin
            write_csr(obpd_pkg::REG_FWD_EXTENT, obpd_pkg::EXTENT_WIDTH'($urandom));
            write_csr(obpd_pkg::REG_LEFT_EXTENT,
                      obpd_pkg::EXTENT_WIDTH'($urandom_range(0, 2000)));
            idle_off = 1;
         end
         random_queries(350);
         drain();
      end
      $display("Sent %0d words over several hitbox settings; %0d results checked, %0d hits.",
               words_sent, board.results_seen, board.hits_seen);
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("** oriented_box_point_distance: PASSED **");
      else begin
         $display("%0d mismatches, %0d results missing", board.mismatches,
                  board.pending.size());
         $display("** oriented_box_point_distance: FAILED **");
      end
      $finish;
   end
endmodule
`default_nettype wire
